FILE: sv/oopp_pkg.sv
// Shared constants and types for the omni-drive particle propagation block.
`default_nettype none
package oopp_pkg;

	// Angles in Q4.28
	localparam logic [30:0] TWO_PI      = 31'd1686629713;
	localparam logic [29:0] PI          = 30'd843314857;
	localparam logic [28:0] HALF_PI     = 29'd421657428;
	// CORDIC gain compensation, Q2.30
	localparam logic [29:0] CORDIC_GAIN = 30'd652032874;

	localparam logic [27:0] ATAN_TAB [32] = '{
		28'd210828714, 28'd124459457, 28'd65760959, 28'd33381290, 28'd16755422,
		28'd8385879, 28'd4193963, 28'd2097109, 28'd1048571, 28'd524287,
		28'd262144, 28'd131072, 28'd65536, 28'd32768, 28'd16384, 28'd8192,
		28'd4096, 28'd2048, 28'd1024, 28'd512, 28'd256, 28'd128, 28'd64,
		28'd32, 28'd16, 28'd8, 28'd4, 28'd2, 28'd1, 28'd0, 28'd0, 28'd0
	};

	// register map indexes
	localparam logic [2:0] REG_ALPHA_RT  = 3'd0;
	localparam logic [2:0] REG_ALPHA_TR  = 3'd1;
	localparam logic [2:0] REG_ALPHA_TT  = 3'd2;
	localparam logic [2:0] REG_ALPHA_RR  = 3'd3;
	localparam logic [2:0] REG_ALPHA_TS  = 3'd4;
	localparam logic [2:0] REG_EPS_LIN   = 3'd5;
	localparam logic [2:0] REG_EPS_ANG   = 3'd6;

	localparam logic [23:0] ALPHA_TS_RESET = 24'd6554;

	typedef struct packed {
		logic signed [31:0] px;
		logic signed [31:0] py;
		logic signed [31:0] pyaw;
		logic               still;
	} pose_t;

endpackage
`default_nettype wire

FILE: sv/omni_odometry_particle_propagate_top.sv
// Omni-drive odometry propagation of particle poses, fully pipelined.
// Throughput: one item per cycle; the longest leg is the 32-stage square root
// in series with the noise scaling, or the CORDIC when it has more than 29 stages.
// The whole pipe advances together and holds while a result waits on out_ready.
// Reset clears the valid bits, the delay lines and loads the register defaults;
// the other data stages are not reset.
`default_nettype none
module omni_odometry_particle_propagate_top #(
	parameter int CORDIC_STAGES = 24
) (
	input  logic               clk,
	input  logic               arst_n,
	// configuration port
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [4:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	// input items
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [31:0] pose_x,
	input  logic signed [31:0] pose_y,
	input  logic signed [31:0] pose_yaw,
	input  logic [30:0]        move_trans,
	input  logic signed [31:0] move_rot,
	input  logic signed [31:0] move_heading,
	input  logic signed [31:0] start_heading,
	input  logic signed [15:0] noise_trans,
	input  logic signed [15:0] noise_rot,
	input  logic signed [15:0] noise_strafe,
	// result items
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] new_x,
	output logic signed [31:0] new_y,
	output logic signed [31:0] new_yaw,
	output logic               moved
);
	import oopp_pkg::*;

	// stage where cos/sin land, stage where noisy motion lands, and their join
	localparam int TRIG_DONE  = 10 + CORDIC_STAGES;
	localparam int NOISE_DONE = 39;
	localparam int JOIN       = (TRIG_DONE > NOISE_DONE) ? TRIG_DONE : NOISE_DONE;
	localparam int LAT        = JOIN + 13;

	// ---------------- saturating helpers ----------------
	function automatic logic [63:0] shsat(input logic [55:0] hi, input logic [55:0] lo,
			input int unsigned sh);
		logic [87:0] p;
		logic [87:0] r;
		p = {hi, 32'd0} + 88'(lo);
		r = p >> sh;
		return (r[87:64] != '0) ? '1 : r[63:0];
	endfunction

	function automatic logic [63:0] satadd(input logic [63:0] a, input logic [63:0] b);
		logic [64:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[64] ? '1 : s[63:0];
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
		if (v > 50'sd2147483647)
			return 32'sh7FFFFFFF;
		else if (v < -50'sd2147483648)
			return 32'sh80000000;
		else
			return 32'(v);
	endfunction

	// ---------------- configuration registers ----------------
	logic [23:0] a_rt_q, a_tr_q, a_tt_q, a_rr_q, a_ts_q;
	logic [30:0] eps_lin_q, eps_ang_q;
	logic [2:0]  reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = paddr[4:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_rt_q    <= '0;
			a_tr_q    <= '0;
			a_tt_q    <= '0;
			a_rr_q    <= '0;
			a_ts_q    <= ALPHA_TS_RESET;
			eps_lin_q <= '0;
			eps_ang_q <= '0;
		end else if (psel && penable && pwrite) begin
			case (reg_idx)
				REG_ALPHA_RT: a_rt_q    <= pwdata[23:0];
				REG_ALPHA_TR: a_tr_q    <= pwdata[23:0];
				REG_ALPHA_TT: a_tt_q    <= pwdata[23:0];
				REG_ALPHA_RR: a_rr_q    <= pwdata[23:0];
				REG_ALPHA_TS: a_ts_q    <= pwdata[23:0];
				REG_EPS_LIN:  eps_lin_q <= pwdata[30:0];
				REG_EPS_ANG:  eps_ang_q <= pwdata[30:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_ALPHA_RT: prdata = {8'd0, a_rt_q};
			REG_ALPHA_TR: prdata = {8'd0, a_tr_q};
			REG_ALPHA_TT: prdata = {8'd0, a_tt_q};
			REG_ALPHA_RR: prdata = {8'd0, a_rr_q};
			REG_ALPHA_TS: prdata = {8'd0, a_ts_q};
			REG_EPS_LIN:  prdata = {1'b0, eps_lin_q};
			REG_EPS_ANG:  prdata = {1'b0, eps_ang_q};
			default:      prdata = '0;
		endcase
	end

	// ---------------- flow control ----------------
	// one advance strobe for every stage; the output stage is the skid point
	logic adv;
	assign adv      = !out_valid || out_ready;
	assign in_ready = adv;

	oopp_delay #(.W(1), .N(LAT)) u_valid (
		.clk(clk), .arst_n(arst_n), .en(adv), .din(in_valid), .dout(out_valid)
	);

	// ---------------- S1: capture ----------------
	logic signed [31:0] x_s1, y_s1, yaw_s1, rot_s1, head_s1, start_s1;
	logic [30:0]        tr_s1;
	logic signed [15:0] nt_s1, nr_s1, ns_s1;

	always_ff @(posedge clk) begin
		if (adv) begin
			x_s1     <= pose_x;
			y_s1     <= pose_y;
			yaw_s1   <= pose_yaw;
			tr_s1    <= move_trans;
			rot_s1   <= move_rot;
			head_s1  <= move_heading;
			start_s1 <= start_heading;
			nt_s1    <= noise_trans;
			nr_s1    <= noise_rot;
			ns_s1    <= noise_strafe;
		end
	end

	logic [31:0]        rmag;
	logic               still;
	logic signed [32:0] dhead;
	pose_t              pose_c;

	assign rmag   = $unsigned(rot_s1[31] ? -rot_s1 : rot_s1);
	assign still  = (tr_s1 < eps_lin_q) && (rmag < {1'b0, eps_ang_q});
	assign dhead  = 33'(head_s1) - 33'(start_s1);
	assign pose_c = '{px: x_s1, py: y_s1, pyaw: yaw_s1, still: still};

	// ---------------- bearing: wrap, add yaw, wrap, CORDIC ----------------
	logic signed [31:0] bear1, bear2, yaw_s4, cos_v, sin_v;
	logic signed [33:0] bsum;

	oopp_wrap #(.W(33)) u_wrap_head (.clk(clk), .en(adv), .ang(dhead), .wrapped(bear1));

	oopp_delay #(.W(32), .N(3)) u_yaw_d (
		.clk(clk), .arst_n(arst_n), .en(adv), .din(yaw_s1), .dout(yaw_s4)
	);

	assign bsum = 34'(bear1) + 34'(yaw_s4);

	oopp_wrap #(.W(34)) u_wrap_bear (.clk(clk), .en(adv), .ang(bsum), .wrapped(bear2));

	oopp_cordic #(.STAGES(CORDIC_STAGES)) u_cordic (
		.clk(clk), .en(adv), .ang(bear2), .cos_v(cos_v), .sin_v(sin_v)
	);

	// ---------------- S2: squares ----------------
	logic [61:0] sqt_s2;
	logic [63:0] sqr_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			sqt_s2 <= 62'(tr_s1) * 62'(tr_s1);
			sqr_s2 <= 64'(rmag) * 64'(rmag);
		end
	end

	// ---------------- S3: alpha partial products (24 x 32 halves) ----------------
	logic [63:0] sqt64;
	logic [55:0] tt_hi_s3, tt_lo_s3, rt_hi_s3, rt_lo_s3, rr_hi_s3, rr_lo_s3;
	logic [55:0] tr_hi_s3, tr_lo_s3, ts_hi_s3, ts_lo_s3;

	assign sqt64 = 64'(sqt_s2);

	always_ff @(posedge clk) begin
		if (adv) begin
			tt_hi_s3 <= 56'(a_tt_q) * 56'(sqt64[63:32]);
			tt_lo_s3 <= 56'(a_tt_q) * 56'(sqt64[31:0]);
			rt_hi_s3 <= 56'(a_rt_q) * 56'(sqr_s2[63:32]);
			rt_lo_s3 <= 56'(a_rt_q) * 56'(sqr_s2[31:0]);
			rr_hi_s3 <= 56'(a_rr_q) * 56'(sqr_s2[63:32]);
			rr_lo_s3 <= 56'(a_rr_q) * 56'(sqr_s2[31:0]);
			tr_hi_s3 <= 56'(a_tr_q) * 56'(sqt64[63:32]);
			tr_lo_s3 <= 56'(a_tr_q) * 56'(sqt64[31:0]);
			ts_hi_s3 <= 56'(a_ts_q) * 56'(sqt64[63:32]);
			ts_lo_s3 <= 56'(a_ts_q) * 56'(sqt64[31:0]);
		end
	end

	// ---------------- S4: scaled, saturated variance terms ----------------
	logic [63:0] t_tt_s4, t_rt_s4, t_rr_s4, t_tr_s4, t_ts_s4;

	always_ff @(posedge clk) begin
		if (adv) begin
			t_tt_s4 <= shsat(tt_hi_s3, tt_lo_s3, 16);
			t_rt_s4 <= shsat(rt_hi_s3, rt_lo_s3, 40);
			t_rr_s4 <= shsat(rr_hi_s3, rr_lo_s3, 24);
			t_tr_s4 <= shsat(tr_hi_s3, tr_lo_s3, 0);
			t_ts_s4 <= shsat(ts_hi_s3, ts_lo_s3, 16);
		end
	end

	// ---------------- S5: variances ----------------
	logic [63:0] vt_s5, vr_s5, vs_s5;

	always_ff @(posedge clk) begin
		if (adv) begin
			vt_s5 <= satadd(t_tt_s4, t_rt_s4);
			vr_s5 <= satadd(t_rr_s4, t_tr_s4);
			vs_s5 <= satadd(t_rt_s4, t_ts_s4);
		end
	end

	// ---------------- S6..S37: standard deviations ----------------
	logic [31:0] sdt, sdr, sds;

	oopp_isqrt u_sqrt_t (.clk(clk), .en(adv), .v(vt_s5), .root(sdt));
	oopp_isqrt u_sqrt_r (.clk(clk), .en(adv), .v(vr_s5), .root(sdr));
	oopp_isqrt u_sqrt_s (.clk(clk), .en(adv), .v(vs_s5), .root(sds));

	// ---------------- S38: noise scaling ----------------
	logic signed [15:0] nt_d, nr_d, ns_d;
	logic [30:0]        tr_d;
	logic signed [31:0] rot_d;
	logic signed [48:0] pt_s38, pr_s38, ps_s38;

	oopp_delay #(.W(48), .N(36)) u_noise_d (
		.clk(clk), .arst_n(arst_n), .en(adv),
		.din({nt_s1, nr_s1, ns_s1}), .dout({nt_d, nr_d, ns_d})
	);

	oopp_delay #(.W(63), .N(37)) u_move_d (
		.clk(clk), .arst_n(arst_n), .en(adv),
		.din({tr_s1, rot_s1}), .dout({tr_d, rot_d})
	);

	always_ff @(posedge clk) begin
		if (adv) begin
			pt_s38 <= 49'($signed({1'b0, sdt})) * 49'(nt_d);
			pr_s38 <= 49'($signed({1'b0, sdr})) * 49'(nr_d);
			ps_s38 <= 49'($signed({1'b0, sds})) * 49'(ns_d);
		end
	end

	// ---------------- S39: noisy translation, rotation, strafe ----------------
	logic signed [49:0] pt_w, pr_w, ps_w, th_w, rh_w;
	logic signed [31:0] th_s39, sh_s39;
	logic signed [40:0] rh_s39;

	assign pt_w = 50'(pt_s38);
	assign pr_w = 50'(pr_s38);
	assign ps_w = 50'(ps_s38);
	assign th_w = $signed({19'd0, tr_d}) + ((pt_w + 50'sd2048) >>> 12);
	assign rh_w = 50'(rot_d) + ((pr_w + 50'sd128) >>> 8);

	always_ff @(posedge clk) begin
		if (adv) begin
			th_s39 <= sat32(th_w);
			rh_s39 <= 41'(rh_w);
			sh_s39 <= sat32((ps_w + 50'sd2048) >>> 12);
		end
	end

	// ---------------- join the motion and trig legs ----------------
	logic signed [31:0] th_j, sh_j, cos_j, sin_j;
	logic signed [40:0] rh_j;
	pose_t              pose_j, pose_o;

	oopp_delay #(.W(105), .N(JOIN - NOISE_DONE)) u_motion_d (
		.clk(clk), .arst_n(arst_n), .en(adv),
		.din({th_s39, rh_s39, sh_s39}), .dout({th_j, rh_j, sh_j})
	);

	oopp_delay #(.W(64), .N(JOIN - TRIG_DONE)) u_trig_d (
		.clk(clk), .arst_n(arst_n), .en(adv),
		.din({cos_v, sin_v}), .dout({cos_j, sin_j})
	);

	oopp_delay #(.W($bits(pose_t)), .N(JOIN - 1)) u_pose_d1 (
		.clk(clk), .arst_n(arst_n), .en(adv), .din(pose_c), .dout(pose_j)
	);

	oopp_delay #(.W($bits(pose_t)), .N(12)) u_pose_d2 (
		.clk(clk), .arst_n(arst_n), .en(adv), .din(pose_j), .dout(pose_o)
	);

	// yaw: add noisy rotation, wrap (12 stages)
	logic signed [41:0] yaw_sum;
	logic signed [31:0] yaw_w;

	assign yaw_sum = 42'(pose_j.pyaw) + 42'(rh_j);

	oopp_wrap #(.W(42)) u_wrap_yaw (.clk(clk), .en(adv), .ang(yaw_sum), .wrapped(yaw_w));

	// displacement rotation: products, then rounded sums
	logic signed [63:0] tc_q1, ss_q1, ts_q1, sc_q1;
	logic signed [31:0] dx_q2, dy_q2, dx_o, dy_o;

	always_ff @(posedge clk) begin
		if (adv) begin
			tc_q1 <= 64'(th_j) * 64'(cos_j);
			ss_q1 <= 64'(sh_j) * 64'(sin_j);
			ts_q1 <= 64'(th_j) * 64'(sin_j);
			sc_q1 <= 64'(sh_j) * 64'(cos_j);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dx_q2 <= 32'((tc_q1 + ss_q1 + 64'sd536870912) >>> 30);
			dy_q2 <= 32'((ts_q1 - sc_q1 + 64'sd536870912) >>> 30);
		end
	end

	oopp_delay #(.W(64), .N(10)) u_disp_d (
		.clk(clk), .arst_n(arst_n), .en(adv),
		.din({dx_q2, dy_q2}), .dout({dx_o, dy_o})
	);

	// ---------------- output stage ----------------
	logic signed [31:0] new_x_q, new_y_q, new_yaw_q;
	logic               moved_q;

	always_ff @(posedge clk) begin
		if (adv) begin
			if (pose_o.still) begin
				new_x_q   <= pose_o.px;
				new_y_q   <= pose_o.py;
				new_yaw_q <= pose_o.pyaw;
				moved_q   <= 1'b0;
			end else begin
				new_x_q   <= pose_o.px + dx_o;
				new_y_q   <= pose_o.py + dy_o;
				new_yaw_q <= yaw_w;
				moved_q   <= 1'b1;
			end
		end
	end

	assign new_x   = new_x_q;
	assign new_y   = new_y_q;
	assign new_yaw = new_yaw_q;
	assign moved   = moved_q;
endmodule
`default_nettype wire

FILE: sv/oopp_delay.sv
// Enabled shift line that carries a word N stages, or passes it straight through when N is 0.
`default_nettype none
module oopp_delay #(
	parameter int W = 1,
	parameter int N = 1
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         en,
	input  logic [W-1:0] din,
	output logic [W-1:0] dout
);
	generate
		if (N == 0) begin : g_pass
			assign dout = din;
		end else begin : g_line
			logic [W-1:0] dly_s [N];
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					for (int i = 0; i < N; i++) dly_s[i] <= '0;
				end else if (en) begin
					dly_s[0] <= din;
					for (int i = 1; i < N; i++) dly_s[i] <= dly_s[i-1];
				end
			end
			assign dout = dly_s[N-1];
		end
	endgenerate
endmodule
`default_nettype wire

FILE: sv/oopp_wrap.sv
// Pipelined angle wrap into (-pi, pi] by restoring subtraction of 2*pi multiples.
`default_nettype none
module oopp_wrap #(
	parameter int W = 33
) (
	input  logic                clk,
	input  logic                en,
	input  logic signed [W-1:0] ang,
	output logic signed [31:0]  wrapped
);
	import oopp_pkg::*;

	localparam int NSTEP = W - 31;

	logic [W-1:0]       rem_s [NSTEP];
	logic               neg_s [NSTEP];
	logic [W-1:0]       mag;
	logic [30:0]        r_last;
	logic [30:0]        pos;
	logic signed [31:0] res_q;

	assign mag = $unsigned(ang[W-1] ? -ang : ang);

	generate
		for (genvar j = 0; j < NSTEP; j++) begin : g_step
			localparam logic [W-1:0] SUB = W'(TWO_PI) << (NSTEP - 1 - j);
			logic [W-1:0] prev;
			logic         prev_neg;
			if (j == 0) begin : g_first
				assign prev     = mag;
				assign prev_neg = ang[W-1];
			end else begin : g_next
				assign prev     = rem_s[j-1];
				assign prev_neg = neg_s[j-1];
			end
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[j] <= (prev >= SUB) ? prev - SUB : prev;
					neg_s[j] <= prev_neg;
				end
			end
		end
	endgenerate

	// floor modulo: a negative input with a nonzero remainder folds back
	assign r_last = rem_s[NSTEP-1][30:0];
	assign pos    = (neg_s[NSTEP-1] && r_last != '0) ? TWO_PI - r_last : r_last;

	always_ff @(posedge clk) begin
		if (en) begin
			if (pos > 31'(PI))
				res_q <= $signed({1'b0, pos}) - $signed({1'b0, TWO_PI});
			else
				res_q <= $signed({1'b0, pos});
		end
	end

	assign wrapped = res_q;
endmodule
`default_nettype wire

FILE: sv/oopp_isqrt.sv
// Pipelined floor square root of a 64-bit value, one result bit per stage.
`default_nettype none
module oopp_isqrt (
	input  logic        clk,
	input  logic        en,
	input  logic [63:0] v,
	output logic [31:0] root
);
	logic [33:0] rem_s  [32];
	logic [31:0] root_s [32];
	logic [63:0] src_s  [32];

	generate
		for (genvar j = 0; j < 32; j++) begin : g_step
			logic [33:0] p_rem;
			logic [31:0] p_root;
			logic [63:0] p_src;
			logic [35:0] cur;
			logic [35:0] trial;
			logic        ge;
			if (j == 0) begin : g_first
				assign p_rem  = '0;
				assign p_root = '0;
				assign p_src  = v;
			end else begin : g_next
				assign p_rem  = rem_s[j-1];
				assign p_root = root_s[j-1];
				assign p_src  = src_s[j-1];
			end
			assign cur   = {p_rem, p_src[63:62]};
			assign trial = {2'b00, p_root, 2'b01};
			assign ge    = cur >= trial;
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[j]  <= ge ? 34'(cur - trial) : 34'(cur);
					root_s[j] <= {p_root[30:0], ge};
					src_s[j]  <= {p_src[61:0], 2'b00};
				end
			end
		end
	endgenerate

	assign root = root_s[31];
endmodule
`default_nettype wire

FILE: sv/oopp_cordic.sv
// Pipelined rotation-mode CORDIC giving cosine and sine in Q2.30.
`default_nettype none
module oopp_cordic #(
	parameter int STAGES = 24
) (
	input  logic               clk,
	input  logic               en,
	input  logic signed [31:0] ang,
	output logic signed [31:0] cos_v,
	output logic signed [31:0] sin_v
);
	import oopp_pkg::*;

	localparam int NUSE = (STAGES < 32) ? STAGES : 32;

	logic signed [33:0] x_s   [NUSE+1];
	logic signed [33:0] y_s   [NUSE+1];
	logic signed [31:0] z_s   [NUSE+1];
	logic               neg_s [NUSE+1];
	logic signed [31:0] z_pre;
	logic               neg_pre;
	logic signed [31:0] cos_q;
	logic signed [31:0] sin_q;

	// fold into the right half plane, flip the result at the end
	always_comb begin
		z_pre   = ang;
		neg_pre = 1'b0;
		if (ang > $signed({3'b000, HALF_PI})) begin
			z_pre   = ang - $signed({2'b00, PI});
			neg_pre = 1'b1;
		end else if (ang < -$signed({3'b000, HALF_PI})) begin
			z_pre   = ang + $signed({2'b00, PI});
			neg_pre = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s[0]   <= $signed({4'b0000, CORDIC_GAIN});
			y_s[0]   <= '0;
			z_s[0]   <= z_pre;
			neg_s[0] <= neg_pre;
		end
	end

	generate
		for (genvar i = 1; i <= NUSE; i++) begin : g_rot
			localparam logic signed [31:0] ATN = $signed({4'b0000, ATAN_TAB[i-1]});
			always_ff @(posedge clk) begin
				if (en) begin
					if (z_s[i-1] >= 0) begin
						x_s[i] <= x_s[i-1] - (y_s[i-1] >>> (i - 1));
						y_s[i] <= y_s[i-1] + (x_s[i-1] >>> (i - 1));
						z_s[i] <= z_s[i-1] - ATN;
					end else begin
						x_s[i] <= x_s[i-1] + (y_s[i-1] >>> (i - 1));
						y_s[i] <= y_s[i-1] - (x_s[i-1] >>> (i - 1));
						z_s[i] <= z_s[i-1] + ATN;
					end
					neg_s[i] <= neg_s[i-1];
				end
			end
		end
	endgenerate

	always_ff @(posedge clk) begin
		if (en) begin
			cos_q <= 32'(neg_s[NUSE] ? -x_s[NUSE] : x_s[NUSE]);
			sin_q <= 32'(neg_s[NUSE] ? -y_s[NUSE] : y_s[NUSE]);
		end
	end

	assign cos_v = cos_q;
	assign sin_v = sin_q;
endmodule
`default_nettype wire

FILE: dv/omni_odometry_particle_propagate_top_tb.sv
// Self-checking testbench for the omni-drive particle propagation block.
`timescale 1ns / 1ps
module omni_odometry_particle_propagate_top_tb;
	import oopp_pkg::*;

	localparam int    STAGES      = 24;
	localparam int    PIPE_DELAY  = 60;     // longer than the pipeline latency
	localparam int    IDLE_LIMIT  = 4000;   // cycles without any handshake
	localparam int    RAND_PHASES = 6;
	localparam int    PHASE_ITEMS = 325;
	localparam longint TWO_PI_Q   = longint'(TWO_PI);
	localparam longint PI_Q       = longint'(PI);
	localparam longint HALF_PI_Q  = longint'(HALF_PI);
	localparam longint GAIN_Q     = longint'(CORDIC_GAIN);

	// register settings a phase can use
	typedef enum int {SET_DEFAULT, SET_EPS_MAX, SET_ALPHA_MAX, SET_RANDOM} setting_e;

	typedef struct packed {
		logic signed [31:0] px, py, pyaw;
		logic [30:0]        trans;
		logic signed [31:0] rot, head, start;
		logic signed [15:0] nt, nr, ns;
	} item_t;

	typedef struct packed {
		logic [31:0] x, y, yaw;
		logic        mv;
	} pose_res_t;

	typedef struct {
		setting_e  setting;
		item_t     it;
		bit        typed;
		pose_res_t res;
	} row_t;

	logic clk = 1'b0, arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [4:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic in_valid = 1'b0, in_ready;
	item_t drv = '0;
	logic out_valid, out_ready = 1'b0;
	logic signed [31:0] new_x, new_y, new_yaw;
	logic moved;

	logic [63:0] cfg_shadow [7];
	pose_res_t   pose_q [$];
	row_t        rows [$];
	int          errors = 0, n_in = 0, n_out = 0, n_still = 0, idle_cnt = 0;
	int          burst_left = 0;
	setting_e    cur_set;

	always #6 clk = ~clk;

	omni_odometry_particle_propagate_top #(.CORDIC_STAGES(STAGES)) i_dut (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
		.in_valid, .in_ready,
		.pose_x(drv.px), .pose_y(drv.py), .pose_yaw(drv.pyaw), .move_trans(drv.trans),
		.move_rot(drv.rot), .move_heading(drv.head), .start_heading(drv.start),
		.noise_trans(drv.nt), .noise_rot(drv.nr), .noise_strafe(drv.ns),
		.out_valid, .out_ready, .new_x, .new_y, .new_yaw, .moved
	);

	// ---------------------------------------------------------------- predictor
	// (a * sq) >> s with saturation to 64 bits
	function automatic logic [63:0] weigh_sq(logic [63:0] a, logic [63:0] sq, int s);
		logic [127:0] p;
		p = ({64'd0, a} * {64'd0, sq}) >> s;
		return (p[127:64] != 0) ? '1 : p[63:0];
	endfunction

	function automatic logic [63:0] sat_sum(logic [63:0] a, logic [63:0] b);
		logic [64:0] r;
		r = {1'b0, a} + {1'b0, b};
		return r[64] ? '1 : r[63:0];
	endfunction

	function automatic logic [63:0] floor_root(logic [63:0] v);
		logic [63:0] res, b;
		res = 0;
		b = 64'd1 << 62;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v = v - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res;
	endfunction

	function automatic longint round_shift(longint v, int s);
		return (v + (longint'(1) << (s - 1))) >>> s;
	endfunction

	function automatic longint clip32(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint wrap_pi(longint v);
		longint r;
		r = v % TWO_PI_Q;
		if (r < 0) r += TWO_PI_Q;
		if (r > PI_Q) r -= TWO_PI_Q;
		return r;
	endfunction

	function automatic pose_res_t propagate_pose(item_t it);
		pose_res_t r;
		longint tr, rot, rmag, sdt, sdr, sds, th, rh, sh, bear, cx, sy, z, nx, dx, dy;
		logic [63:0] sqt, sqr, vt, vr, vs;
		bit flip;
		tr   = longint'(it.trans);
		rot  = longint'(it.rot);
		rmag = rot < 0 ? -rot : rot;
		if (tr < longint'(cfg_shadow[REG_EPS_LIN]) && rmag < longint'(cfg_shadow[REG_EPS_ANG])) begin
			r.x = it.px; r.y = it.py; r.yaw = it.pyaw; r.mv = 1'b0;
			return r;
		end
		sqt = tr * tr;
		sqr = rmag * rmag;
		vt = sat_sum(weigh_sq(cfg_shadow[REG_ALPHA_TT], sqt, 16),
			weigh_sq(cfg_shadow[REG_ALPHA_RT], sqr, 40));
		vr = sat_sum(weigh_sq(cfg_shadow[REG_ALPHA_RR], sqr, 24),
			weigh_sq(cfg_shadow[REG_ALPHA_TR], sqt, 0));
		vs = sat_sum(weigh_sq(cfg_shadow[REG_ALPHA_RT], sqr, 40),
			weigh_sq(cfg_shadow[REG_ALPHA_TS], sqt, 16));
		sdt = longint'(floor_root(vt));
		sdr = longint'(floor_root(vr));
		sds = longint'(floor_root(vs));
		th = clip32(tr + round_shift(sdt * longint'(it.nt), 12));
		rh = rot + round_shift(sdr * longint'(it.nr), 8);
		sh = clip32(round_shift(sds * longint'(it.ns), 12));
		bear = wrap_pi(wrap_pi(longint'(it.head) - longint'(it.start)) + longint'(it.pyaw));
		// rotation-mode CORDIC, folded into the right half-plane
		cx = GAIN_Q; sy = 0; z = bear; flip = 0;
		if (z > HALF_PI_Q) begin
			z -= PI_Q; flip = 1;
		end else if (z < -HALF_PI_Q) begin
			z += PI_Q; flip = 1;
		end
		for (int i = 0; i < STAGES && i < 32; i++) begin
			if (z >= 0) begin
				nx = cx - (sy >>> i); sy = sy + (cx >>> i); z -= longint'(ATAN_TAB[i]);
			end else begin
				nx = cx + (sy >>> i); sy = sy - (cx >>> i); z += longint'(ATAN_TAB[i]);
			end
			cx = nx;
		end
		if (flip) begin
			cx = -cx; sy = -sy;
		end
		dx = round_shift(th * cx + sh * sy, 30);
		dy = round_shift(th * sy - sh * cx, 30);
		r.x   = 32'(longint'(it.px) + dx);
		r.y   = 32'(longint'(it.py) + dy);
		r.yaw = 32'(wrap_pi(longint'(it.pyaw) + rh));
		r.mv  = 1'b1;
		return r;
	endfunction

	// ---------------------------------------------------------------- config port
	task automatic reg_write(logic [2:0] idx, logic [31:0] val);
		logic [31:0] mask;
		mask = (idx < REG_EPS_LIN) ? 32'h00FF_FFFF : 32'h7FFF_FFFF;
		@(negedge clk);
		psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0; paddr <= {idx, 2'b00}; pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		cfg_shadow[idx] = 64'(val & mask);
		// read back
		pwrite <= 1'b0; penable <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata != (val & mask)) begin
			errors++;
			if (errors <= 10)
				$display("reg %0d readback: expected %h got %h", idx, val & mask, prdata);
		end
		@(negedge clk);
		psel <= 1'b0; penable <= 1'b0;
	endtask

	// pipe must be empty before any register changes
	task automatic drain_pipe();
		while (pose_q.size() != 0) @(posedge clk);
		repeat (PIPE_DELAY) @(posedge clk);
	endtask

	function automatic logic [31:0] pick_alpha();
		case ($urandom_range(0, 5))
			0: return 32'd0;
			1: return 32'hFFFFFF;
			2: return $urandom;
			default: return $urandom_range(0, 1 << 17);
		endcase
	endfunction

	task automatic apply_setting(setting_e s);
		logic [31:0] a [5];
		logic [31:0] el, ea;
		drain_pipe();
		case (s)
			SET_DEFAULT: begin
				a = '{0, 0, 0, 0, ALPHA_TS_RESET}; el = 0; ea = 0;
			end
			SET_EPS_MAX: begin
				a = '{0, 0, 0, 0, 0}; el = 32'h7FFF_FFFF; ea = 32'h7FFF_FFFF;
			end
			SET_ALPHA_MAX: begin
				a = '{32'hFFFFFF, 32'hFFFFFF, 32'hFFFFFF, 32'hFFFFFF, 32'hFFFFFF};
				el = 0; ea = 0;
			end
			default: begin
				foreach (a[i]) a[i] = pick_alpha();
				el = $urandom_range(0, 1 << 20);
				ea = $urandom_range(0, 1 << 26);
			end
		endcase
		reg_write(REG_ALPHA_RT, a[0]);
		reg_write(REG_ALPHA_TR, a[1]);
		reg_write(REG_ALPHA_TT, a[2]);
		reg_write(REG_ALPHA_RR, a[3]);
		reg_write(REG_ALPHA_TS, a[4]);
		reg_write(REG_EPS_LIN, el);
		reg_write(REG_EPS_ANG, ea);
		cur_set = s;
	endtask

	// ---------------------------------------------------------------- sender
	task automatic send_item(item_t it, bit typed, pose_res_t typed_res);
		int gap;
		@(negedge clk);
		in_valid <= 1'b1;
		drv <= it;
		do @(posedge clk); while (!in_ready);
		pose_q.push_back(typed ? typed_res : propagate_pose(it));
		n_in++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(1, 40);
			gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				@(negedge clk);
				in_valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
	endtask

	function automatic item_t random_item();
		item_t it;
		it.px = $urandom; it.py = $urandom; it.pyaw = $urandom;
		it.head = $urandom; it.start = $urandom;
		it.nt = 16'($urandom); it.nr = 16'($urandom); it.ns = 16'($urandom);
		case ($urandom_range(0, 3))
			0: begin  // near the still thresholds
				it.trans = 31'($urandom_range(0, 1 << 21));
				it.rot = $signed($urandom_range(0, 1 << 27)) - (1 << 26);
			end
			1: begin
				it.trans = 31'($urandom); it.rot = $urandom;
			end
			default: begin  // ordinary odometry steps
				it.trans = 31'($urandom_range(0, 1 << 19));
				it.rot = $signed($urandom_range(0, 1 << 28)) - (1 << 27);
			end
		endcase
		return it;
	endfunction

	function automatic void add_row(setting_e s, item_t it, bit typed, pose_res_t r);
		row_t row;
		row.setting = s; row.it = it; row.typed = typed; row.res = r;
		rows.push_back(row);
	endfunction

	// pose unchanged; under the default setting a zero step still counts as moved
	function automatic pose_res_t same_pose(item_t it, logic mv);
		pose_res_t r;
		r.x = it.px; r.y = it.py; r.yaw = it.pyaw; r.mv = mv;
		return r;
	endfunction

	function automatic item_t mk(logic [31:0] px, logic [31:0] py, logic [31:0] yaw,
			logic [30:0] tr, logic [31:0] rot, logic [31:0] hd, logic [31:0] st,
			logic [15:0] nt, logic [15:0] nr, logic [15:0] ns);
		item_t it;
		it.px = px; it.py = py; it.pyaw = yaw; it.trans = tr; it.rot = rot;
		it.head = hd; it.start = st; it.nt = nt; it.nr = nr; it.ns = ns;
		return it;
	endfunction

	// ---------------------------------------------------------------- receiver
	int        rdy_hold = 0, rdy_mode = 2;
	always @(negedge clk) begin
		if (rdy_hold == 0) begin
			rdy_mode = $urandom_range(0, 3);
			rdy_hold = rdy_mode == 0 ? $urandom_range(1, 30) : $urandom_range(1, 60);
		end
		rdy_hold--;
		out_ready <= (rdy_mode == 0) ? 1'b0 : (rdy_mode == 1) ? 1'($urandom_range(0, 1)) : 1'b1;
	end

	// ---------------------------------------------------------------- checker and watchdog
	always @(posedge clk) begin
		pose_res_t want;
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cnt = 0;
			else idle_cnt++;
			if (idle_cnt >= IDLE_LIMIT) begin
				$display("watchdog: no handshake for %0d cycles", IDLE_LIMIT);
				$display("omni_odometry_particle_propagate_top test failed");
				$finish;
			end
			if (out_valid && out_ready) begin
				n_out++;
				if (pose_q.size() == 0) begin
					errors++;
					if (errors <= 10) $display("unexpected result item at %0t", $realtime);
				end else begin
					want = pose_q.pop_front();
					if (!moved) n_still++;
					if (new_x !== want.x || new_y !== want.y || new_yaw !== want.yaw
							|| moved !== want.mv) begin
						errors++;
						if (errors <= 10)
							$display("item %0d: expected x %h y %h yaw %h mv %b, got %h %h %h %b",
								n_out, want.x, want.y, want.yaw, want.mv,
								new_x, new_y, new_yaw, moved);
					end
				end
			end
		end
	end

	// ---------------------------------------------------------------- main sequence
	initial begin
		item_t it;
		pose_res_t none;
		none = '0;
		for (int i = 0; i < 7; i++) cfg_shadow[i] = 0;
		cfg_shadow[REG_ALPHA_TS] = ALPHA_TS_RESET;
		cur_set = SET_DEFAULT;

		// reset values: zero steps leave the pose where it is
		it = mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
		add_row(SET_DEFAULT, it, 1, same_pose(it, 1));
		it = mk(32'h7FFF_FFFF, 32'h7FFF_FFFF, PI, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000,
			16'h7FFF, 16'h7FFF, 16'h7FFF);
		add_row(SET_DEFAULT, it, 1, same_pose(it, 1));
		// -pi+1 lands on pi after the yaw wrap, since 2*pi is odd in Q4.28
		it = mk(32'h8000_0000, 32'h8000_0000, -PI + 1, 0, 0, 32'h8000_0000, 32'h7FFF_FFFF,
			16'h8000, 16'h8000, 16'h8000);
		add_row(SET_DEFAULT, it, 0, none);
		add_row(SET_DEFAULT, mk(0, 0, 0, 31'h7FFF_FFFF, 0, 0, 0, 16'h7FFF, 0, 16'h7FFF), 0, none);
		add_row(SET_DEFAULT, mk(5, 7, 32'h7FFF_FFFF, 1 << 16, 32'h7FFF_FFFF, PI, -PI,
			0, 16'h7FFF, 0), 0, none);
		add_row(SET_DEFAULT, mk(32'hFFFF_FFFF, 1, 32'h8000_0000, 1 << 18, 32'h8000_0000,
			HALF_PI, 0, 16'h8000, 16'h8000, 16'h8000), 0, none);
		add_row(SET_DEFAULT, mk(32'h7FFF_0000, 32'h8000_FFFF, HALF_PI, 31'h7FFF_FFFF,
			0, 0, 0, 0, 0, 0), 0, none);

		// big thresholds: item passes untouched, yaw not wrapped
		it = mk(32'h1234_5678, 32'h8765_4321, 32'h7FFF_FFFF, 31'h7FFF_FFFE, 32'h7FFF_FFFE,
			0, 0, 16'h7FFF, 16'h7FFF, 16'h7FFF);
		add_row(SET_EPS_MAX, it, 1, same_pose(it, 0));
		it = mk(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 0, 32'h8000_0002,
			32'h8000_0000, 32'h7FFF_FFFF, 16'h8000, 16'h8000, 16'h8000);
		add_row(SET_EPS_MAX, it, 1, same_pose(it, 0));
		// threshold edges: translation equal to eps, most negative rotation
		add_row(SET_EPS_MAX, mk(1, 2, 3, 31'h7FFF_FFFF, 0, 0, 0, 0, 0, 0), 0, none);
		add_row(SET_EPS_MAX, mk(1, 2, 3, 0, 32'h8000_0000, PI, 0, 0, 0, 0), 0, none);
		add_row(SET_EPS_MAX, mk(1, 2, 3, 0, 32'h7FFF_FFFF, 0, 0, 0, 0, 0), 0, none);

		// full alphas: variances saturate and noisy moves clip
		add_row(SET_ALPHA_MAX, mk(0, 0, 0, 31'h7FFF_FFFF, 32'h8000_0000, 0, 0,
			16'h7FFF, 16'h7FFF, 16'h7FFF), 0, none);
		add_row(SET_ALPHA_MAX, mk(0, 0, 0, 31'h7FFF_FFFF, 32'h7FFF_FFFF, PI, HALF_PI,
			16'h8000, 16'h8000, 16'h8000), 0, none);
		add_row(SET_ALPHA_MAX, mk(32'h7FFF_FFFF, 32'h8000_0000, -PI + 1, 1 << 16, 1 << 28,
			-HALF_PI, HALF_PI, 16'h1000, 16'hF000, 16'h1000), 0, none);
		add_row(SET_ALPHA_MAX, mk(100, 200, 300, 0, 0, 0, 0, 16'h7FFF, 16'h7FFF, 16'h8000),
			0, none);
		add_row(SET_ALPHA_MAX, mk(32'hDEAD_BEEF, 32'h0BAD_F00D, 32'h5555_5555, 31'h2AAA_AAAA,
			32'hAAAA_AAAA, 32'h3333_3333, 32'hCCCC_CCCC, 16'h5555, 16'hAAAA, 16'h3C3C), 0, none);

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset values of the registers are in effect for the first rows
		foreach (rows[i]) begin
			if (rows[i].setting != cur_set) begin
				@(negedge clk);
				in_valid <= 1'b0;
				apply_setting(rows[i].setting);
			end
			send_item(rows[i].it, rows[i].typed, rows[i].res);
		end
		@(negedge clk);
		in_valid <= 1'b0;
		apply_setting(SET_DEFAULT);

		// random phases; each starts from an empty pipe
		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			@(negedge clk);
			in_valid <= 1'b0;
			case (ph)
				1: apply_setting(SET_ALPHA_MAX);
				3: apply_setting(SET_EPS_MAX);
				default: apply_setting(SET_RANDOM);
			endcase
			for (int k = 0; k < PHASE_ITEMS; k++) send_item(random_item(), 0, none);
		end
		@(negedge clk);
		in_valid <= 1'b0;

		while (pose_q.size() != 0) @(posedge clk);
		repeat (PIPE_DELAY) @(posedge clk);

		$display("%0d items sent, %0d results checked, %0d held still; %0d register settings",
			n_in, n_out, n_still, RAND_PHASES + 4);
		$display("covered zero steps, threshold edges, saturated variances and random poses");
		if (errors == 0 && pose_q.size() == 0) begin
			$display("omni_odometry_particle_propagate_top test passed");
		end else begin
			$display("%0d mismatches", errors);
			$display("omni_odometry_particle_propagate_top test failed");
		end
		$finish;
	end

endmodule
